### hw/rtl/timeout_timer_bank_core_assert.svh
// assertion macros used by the timer bank core rtl
`ifndef TIMEOUT_TIMER_BANK_CORE_ASSERT_SVH
`define TIMEOUT_TIMER_BANK_CORE_ASSERT_SVH

// same-cycle implication
`define TTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("timer bank assertion failed");

// next-cycle implication
`define TTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timer bank assertion failed");

`endif

### hw/rtl/ttb_pkg.sv
package ttb_pkg;

	localparam int NUM_TIMERS_DEF = 8;
	localparam int DUR_W = 48;
	localparam int TIME_W = 63;
	localparam int IDX_W = 3;
	localparam int CNT_W = 4;

	localparam logic [1:0] CMD_RESET_ONE = 2'd0;
	localparam logic [1:0] CMD_RESET_ALL = 2'd1;
	localparam logic [1:0] CMD_SCAN = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [IDX_W-1:0]  timer_index;
		logic [DUR_W-1:0]  duration;
		logic [TIME_W-1:0] now_time;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] expired_index;
		logic             is_summary;
		logic [CNT_W-1:0] expired_count;
		logic             shortest_valid;
		logic [DUR_W-1:0] shortest_remaining;
		logic             watched_expired;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [DUR_W-1:0]  dur;
		logic [TIME_W-1:0] start;
		logic              started;
	} timer_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic take;
	} ev_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [CNT_W-1:0] count;
		logic             sv;
		logic [DUR_W-1:0] shortest;
		logic             watched;
	} ev_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_REPORT
	} state_t;

endpackage

### hw/rtl/ttb_cell.sv
module ttb_cell
	import ttb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  timer_t            nbr,
	input  logic [TIME_W-1:0] now,
	input  logic [DUR_W-1:0]  dur,
	output timer_t            held
);

	timer_t timer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (ctl.load) begin
			timer_q.start <= now;
			timer_q.started <= 1'b1;
			if (dur != '0) begin
				timer_q.dur <= dur;
			end
		end else if (ctl.shift) begin
			timer_q <= nbr;
		end
	end

	assign held = timer_q;

endmodule

### hw/rtl/ttb_eval.sv
module ttb_eval
	import ttb_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	localparam int CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
	localparam int EW = (CW > IDX_W) ? CW : IDX_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ev_ctl_t           ctl,
	input  timer_t            head,
	input  logic [TIME_W-1:0] now,
	input  logic [IDX_W-1:0]  watch,
	input  logic [CW-1:0]     pos,
	output ev_sts_t           sts
);

	logic              act_s1;
	logic              live_s1;
	logic [CW-1:0]     pos_s1;
	logic              neg_s1;
	logic [TIME_W-1:0] fwd_s1;
	logic [TIME_W-1:0] back_s1;
	logic [DUR_W-1:0]  dur_s1;

	logic [TIME_W:0]   diff;
	logic [TIME_W-1:0] bck;

	logic              expired;
	logic [DUR_W-1:0]  rem_f;
	logic [DUR_W:0]    sum_b;
	logic              sat;
	logic [DUR_W-1:0]  rem;

	logic [CNT_W-1:0]  count_q;
	logic              sv_q;
	logic [DUR_W-1:0]  shortest_q;
	logic              watched_q;

	// elapsed time both ways
	always_comb begin
		diff = {1'b0, now} - {1'b0, head.start};
		bck = head.start - now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= ctl.take;
		end
	end

	always_ff @(posedge clk) begin
		live_s1 <= (head.dur != '0) && head.started;
		pos_s1 <= pos;
		neg_s1 <= diff[TIME_W];
		fwd_s1 <= diff[TIME_W-1:0];
		back_s1 <= bck;
		dur_s1 <= head.dur;
	end

	always_comb begin
		expired = !neg_s1 && ((|fwd_s1[TIME_W-1:DUR_W]) || (fwd_s1[DUR_W-1:0] >= dur_s1));
		rem_f = dur_s1 - fwd_s1[DUR_W-1:0];
		sum_b = {1'b0, dur_s1} + {1'b0, back_s1[DUR_W-1:0]};
		sat = (|back_s1[TIME_W-1:DUR_W]) || sum_b[DUR_W];
		if (neg_s1) begin
			rem = sat ? '1 : sum_b[DUR_W-1:0];
		end else begin
			rem = rem_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sv_q <= 1'b0;
			shortest_q <= '0;
			watched_q <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			sv_q <= 1'b0;
			shortest_q <= '0;
			watched_q <= 1'b0;
		end else if (act_s1 && live_s1) begin
			if (expired) begin
				count_q <= count_q + CNT_W'(1);
				if (EW'(pos_s1) == EW'(watch)) begin
					watched_q <= 1'b1;
				end
			end else if (!sv_q || (rem < shortest_q)) begin
				shortest_q <= rem;
				sv_q <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.hit = act_s1 && live_s1 && expired;
		sts.hit_idx = IDX_W'(pos_s1);
		sts.count = count_q;
		sts.sv = sv_q;
		sts.shortest = shortest_q;
		sts.watched = watched_q;
	end

endmodule

### hw/rtl/timeout_timer_bank_core.sv
// Bank of NUM_TIMERS timeout timers held in a ring of cells. A reset command
// (one timer or all), like any other non-scan command, is taken with busy low;
// its acknowledge word is on result, with strobe high, in the cycle after
// start. A scan rotates the ring one timer per cycle past a single
// subtract-and-compare unit; busy is high in the scan, flush and report states;
// each expired timer gives one word in ascending index order and the summary
// word comes last. Words are strobed for one cycle and cannot be held off.
`include "timeout_timer_bank_core_assert.svh"

module timeout_timer_bank_core
	import ttb_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	localparam int CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int EW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [CW-1:0] LAST_POS = CW'(NUM_TIMERS - 1);

	state_t            state_q;
	state_t            state_d;
	logic [CW-1:0]     cnt_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  watch_q;
	logic              strobe_q;
	result_t           result_q;
	result_t           result_d;

	logic              acc;
	logic              is_scan;
	logic              shift;
	ev_ctl_t           ev_ctl;
	ev_sts_t           ev_sts;

	timer_t            held [NUM_TIMERS];
	cell_ctl_t         cell_ctl [NUM_TIMERS];
	timer_t            head_upd;

	always_comb begin
		acc = start && !busy;
		is_scan = item.command == CMD_SCAN;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && is_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_POS) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_REPORT;
			ST_REPORT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		shift = state_q == ST_SCAN;
		ev_ctl.clear = acc && is_scan;
		ev_ctl.take = state_q == ST_SCAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_scan) begin
			now_q <= item.now_time;
			watch_q <= item.timer_index;
		end
	end

	// a set timer that never started takes the scan time as it leaves the head
	always_comb begin
		head_upd = held[0];
		if ((held[0].dur != '0) && !held[0].started) begin
			head_upd.start = now_q;
			head_upd.started = 1'b1;
		end
	end

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		timer_t nbr;

		assign cell_ctl[i].shift = shift;
		assign cell_ctl[i].load = acc && ((item.command == CMD_RESET_ALL) ||
			((item.command == CMD_RESET_ONE) && (EW'(item.timer_index) == EW'(i))));

		if (i == NUM_TIMERS - 1) begin : g_tail
			assign nbr = head_upd;
		end else begin : g_mid
			assign nbr = held[i+1];
		end

		ttb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl[i]),
			.nbr    (nbr),
			.now    (item.now_time),
			.dur    (item.duration),
			.held   (held[i])
		);
	end

	ttb_eval #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ev_ctl),
		.head   (held[0]),
		.now    (now_q),
		.watch  (watch_q),
		.pos    (cnt_q),
		.sts    (ev_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (acc && !is_scan) || ev_sts.hit || (state_q == ST_REPORT);
		end
	end

	always_comb begin
		result_d = '0;
		if (acc && !is_scan) begin
			result_d.is_summary = 1'b1;
			result_d.last = 1'b1;
		end else if (ev_sts.hit) begin
			result_d.expired_index = ev_sts.hit_idx;
		end else if (state_q == ST_REPORT) begin
			result_d.is_summary = 1'b1;
			result_d.expired_count = ev_sts.count;
			result_d.shortest_valid = ev_sts.sv;
			result_d.shortest_remaining = ev_sts.shortest;
			result_d.watched_expired = ev_sts.watched;
			result_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`TTB_ASSERT_NEXT(a_report_word, clk, arst_n, state_q == ST_REPORT, strobe_q && result_q.last)
	`TTB_ASSERT_NEXT(a_ack_word, clk, arst_n, acc && !is_scan, strobe_q && result_q.is_summary)
	`TTB_ASSERT_NEXT(a_scan_end, clk, arst_n, state_q == ST_SCAN && cnt_q == LAST_POS, state_q == ST_FLUSH)
	`TTB_ASSERT_IMP(a_hit_busy, clk, arst_n, ev_sts.hit, state_q == ST_SCAN || state_q == ST_FLUSH)

endmodule

### tb/tb_timeout_timer_bank_core.sv
`timescale 1ns / 100ps

module tb_timeout_timer_bank_core;
	import ttb_pkg::*;

	localparam int NT = NUM_TIMERS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] MAX_NOW = {TIME_W{1'b1}};
	localparam logic [DUR_W-1:0] MAX_DUR = {DUR_W{1'b1}};
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	timeout_timer_bank_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	// predicted timer bank
	logic [DUR_W-1:0]  timer_dur [NT];
	logic [TIME_W-1:0] timer_begin [NT];
	logic              timer_running [NT];

	result_t pending_words[$];
	int mismatch_count;
	int stall_cycles;
	int idle_pct;
	logic [TIME_W-1:0] sim_us;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic arm_timer(int i, logic [TIME_W-1:0] now, logic [DUR_W-1:0] dur);
		timer_begin[i] = now;
		timer_running[i] = 1'b1;
		if (dur != '0)
			timer_dur[i] = dur;
	endtask

	// works out the words one command produces and updates the timer state
	task automatic predict_words(item_t it);
		result_t w;
		logic [63:0] now;
		logic [63:0] st;
		logic [63:0] el;
		logic [63:0] rem;
		logic [63:0] best;
		logic [CNT_W-1:0] cnt;
		logic found;
		logic watch;
		now = {1'b0, it.now_time};
		if (it.command == CMD_SCAN) begin
			cnt = '0;
			found = 1'b0;
			best = '0;
			watch = 1'b0;
			for (int i = 0; i < NT; i++) begin
				if (timer_dur[i] != '0) begin
					if (!timer_running[i]) begin
						timer_begin[i] = it.now_time;
						timer_running[i] = 1'b1;
					end else begin
						st = {1'b0, timer_begin[i]};
						rem = '1;
						if (now >= st) begin
							el = now - st;
							if (el >= {16'd0, timer_dur[i]}) begin
								w = '0;
								w.expired_index = IDX_W'(i);
								pending_words.push_back(w);
								cnt++;
								if (i == it.timer_index)
									watch = 1'b1;
							end else begin
								rem = {16'd0, timer_dur[i]} - el;
							end
						end else begin
							rem = {16'd0, timer_dur[i]} + (st - now);
							if (rem > {16'd0, MAX_DUR})
								rem = {16'd0, MAX_DUR};
						end
						if (rem != '1 && (!found || rem < best)) begin
							best = rem;
							found = 1'b1;
						end
					end
				end
			end
			w = '0;
			w.is_summary = 1'b1;
			w.expired_count = cnt;
			w.shortest_valid = found;
			w.shortest_remaining = found ? best[DUR_W-1:0] : '0;
			w.watched_expired = watch;
			w.last = 1'b1;
			pending_words.push_back(w);
		end else begin
			if (it.command == CMD_RESET_ONE) begin
				if (it.timer_index < NT)
					arm_timer(it.timer_index, it.now_time, it.duration);
			end else if (it.command == CMD_RESET_ALL) begin
				for (int i = 0; i < NT; i++)
					arm_timer(i, it.now_time, it.duration);
			end
			w = '0;
			w.is_summary = 1'b1;
			w.last = 1'b1;
			pending_words.push_back(w);
		end
	endtask

	function automatic item_t mk(logic [1:0] cmd, int idx, logic [DUR_W-1:0] dur,
			logic [TIME_W-1:0] now);
		item_t it;
		it.command = cmd;
		it.timer_index = IDX_W'(idx);
		it.duration = dur;
		it.now_time = now;
		return it;
	endfunction

	task automatic send_word(item_t it);
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		predict_words(it);
	endtask

	// sender pauses until every predicted word has come back
	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_bank;
		send_word(mk(CMD_SCAN, 0, '0, '0));
		send_word(mk(CMD_UNUSED, 7, MAX_DUR, MAX_NOW));
		send_word(mk(CMD_RESET_ONE, 5, '0, 50));
		send_word(mk(CMD_SCAN, 5, '0, 60));
		drain();
	endtask

	task automatic test_expiry;
		send_word(mk(CMD_RESET_ALL, 0, 10, 100));
		send_word(mk(CMD_SCAN, 2, '0, 105));
		send_word(mk(CMD_SCAN, 7, '0, 110));
		send_word(mk(CMD_RESET_ONE, 2, '0, 110));
		send_word(mk(CMD_SCAN, 2, '0, 115));
		drain();
	endtask

	task automatic test_each_timer;
		for (int i = 0; i < NT; i++)
			send_word(mk(CMD_RESET_ONE, i, DUR_W'(i + 1), 1000));
		send_word(mk(CMD_SCAN, 3, '0, 1004));
		drain();
	endtask

	task automatic test_time_extremes;
		send_word(mk(CMD_RESET_ONE, 6, MAX_DUR, MAX_NOW));
		send_word(mk(CMD_SCAN, 6, '0, '0));
		send_word(mk(CMD_RESET_ONE, 1, 5, 1000));
		send_word(mk(CMD_SCAN, 1, '0, 990));
		send_word(mk(CMD_SCAN, 6, '0, MAX_NOW));
		drain();
	endtask

	task automatic random_item(output item_t it);
		int pick;
		int r;
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		if (r < 25)
			it.duration = '0;
		else if (r < 75)
			it.duration = DUR_W'($urandom_range(1, 2000));
		else
			it.duration = {16'($urandom_range(0, 16'hffff)), 32'($urandom)};
		sim_us = sim_us + TIME_W'($urandom_range(0, 300));
		r = $urandom_range(0, 99);
		if (r < 8)
			it.now_time = {31'($urandom), 32'($urandom)};
		else if (r < 16)
			it.now_time = sim_us - TIME_W'($urandom_range(0, 500));
		else
			it.now_time = sim_us;
		if (pick < 45)
			it.command = CMD_SCAN;
		else if (pick < 80)
			it.command = CMD_RESET_ONE;
		else if (pick < 93)
			it.command = CMD_RESET_ALL;
		else
			it.command = CMD_UNUSED;
		it.timer_index = IDX_W'($urandom_range(0, NT - 1));
	endtask

	task automatic run_random(int n, int pct);
		item_t it;
		idle_pct = pct;
		repeat (n) begin
			random_item(it);
			send_word(it);
		end
		drain();
		idle_pct = 0;
	endtask

	task automatic test_random_no_idle;
		run_random(74, 0);
	endtask

	task automatic test_random_sender_idle;
		run_random(73, 53);
	endtask

	task automatic test_random_mixed_idle;
		run_random(73, 17);
	endtask

	always @(posedge clk) begin
		result_t exp_w;
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: idx=%0d sum=%0b cnt=%0d sv=%0b rem=%0d we=%0b last=%0b",
						result.expired_index, result.is_summary, result.expired_count,
						result.shortest_valid, result.shortest_remaining,
						result.watched_expired, result.last);
			end else begin
				exp_w = pending_words.pop_front();
				if (result.expired_index !== exp_w.expired_index
						|| result.is_summary !== exp_w.is_summary
						|| result.expired_count !== exp_w.expired_count
						|| result.shortest_valid !== exp_w.shortest_valid
						|| result.shortest_remaining !== exp_w.shortest_remaining
						|| result.watched_expired !== exp_w.watched_expired
						|| result.last !== exp_w.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch exp: idx=%0d sum=%0b cnt=%0d sv=%0b rem=%0d we=%0b last=%0b",
							exp_w.expired_index, exp_w.is_summary, exp_w.expired_count,
							exp_w.shortest_valid, exp_w.shortest_remaining,
							exp_w.watched_expired, exp_w.last);
						$display("         got: idx=%0d sum=%0b cnt=%0d sv=%0b rem=%0d we=%0b last=%0b",
							result.expired_index, result.is_summary, result.expired_count,
							result.shortest_valid, result.shortest_remaining,
							result.watched_expired, result.last);
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		mismatch_count = 0;
		stall_cycles = 0;
		idle_pct = 0;
		sim_us = 5000;
		for (int i = 0; i < NT; i++) begin
			timer_dur[i] = '0;
			timer_begin[i] = '0;
			timer_running[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_bank();
		test_expiry();
		test_each_timer();
		test_time_extremes();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_mixed_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_cell.sv
hw/rtl/ttb_eval.sv
hw/rtl/timeout_timer_bank_core.sv
tb/tb_timeout_timer_bank_core.sv
